>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/ptc8_pkg.sv
// ----------------------------------------------------------------------------
// ptc8_pkg
// Types and constants of the 8-bit prescaled timer/counter.
// ----------------------------------------------------------------------------
package ptc8_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    REG_CTRL_A  = 3'd0,
    REG_CTRL_B  = 3'd1,
    REG_COUNT   = 3'd2,
    REG_CMP_A   = 3'd3,
    REG_CMP_B   = 3'd4,
    REG_MASK    = 3'd5,
    REG_FLAGS   = 3'd6
  } reg_addr_t;

  // clock source select, ctrl B bits 2:0
  localparam logic [2:0] CS_STOP    = 3'd0;
  localparam logic [2:0] CS_DIV1    = 3'd1;
  localparam logic [2:0] CS_DIV8    = 3'd2;
  localparam logic [2:0] CS_DIV64   = 3'd3;
  localparam logic [2:0] CS_DIV256  = 3'd4;
  localparam logic [2:0] CS_DIV1024 = 3'd5;

  // wave modes where compare A clears the count
  localparam logic [2:0] MODE_CLR_A = 3'd2;
  localparam logic [2:0] MODE_CLR_B = 3'd7;

  localparam int PS_W = 11;

  localparam logic [PS_W-1:0] DIV_8    = 11'd8;
  localparam logic [PS_W-1:0] DIV_64   = 11'd64;
  localparam logic [PS_W-1:0] DIV_256  = 11'd256;
  localparam logic [PS_W-1:0] DIV_1024 = 11'd1024;

  localparam int FLAG_OVF = 0;
  localparam int FLAG_CMA = 1;
  localparam int FLAG_CMB = 2;

  typedef struct packed {
    logic [7:0]      ctrl_a;
    logic [7:0]      ctrl_b;
    logic [7:0]      count_value;
    logic [7:0]      compare_a;
    logic [7:0]      compare_b;
    logic [7:0]      irq_mask;
    logic [7:0]      irq_flags;
    logic [PS_W-1:0] prescale_ticks;
  } tmr_state_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] flags_now;
    logic       overflow_irq;
    logic       compare_a_irq;
    logic       compare_b_irq;
  } tmr_result_t;

  function automatic logic [PS_W-1:0] divider_of(input logic [2:0] src);
    logic [PS_W-1:0] d;
    case (src)
      CS_DIV8:    d = DIV_8;
      CS_DIV64:   d = DIV_64;
      CS_DIV256:  d = DIV_256;
      CS_DIV1024: d = DIV_1024;
      default:    d = '0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/ptc8_step.sv
// ----------------------------------------------------------------------------
// ptc8_step
// Next-state and result logic for one transaction: tick, read or write.
// ----------------------------------------------------------------------------
module ptc8_step (
  input  ptc8_pkg::tmr_state_t  cur,
  input  ptc8_pkg::op_t         op,
  input  logic [2:0]            reg_addr,
  input  logic [7:0]            write_data,
  output ptc8_pkg::tmr_state_t  nxt,
  output ptc8_pkg::tmr_result_t res
);
  import ptc8_pkg::*;

  logic [2:0]      src;
  logic [2:0]      mode;
  logic [PS_W-1:0] ps_inc;
  logic [7:0]      count1;
  logic            ovf;
  logic            cma;
  logic            cmb;

  assign src    = cur.ctrl_b[2:0];
  assign mode   = {cur.ctrl_b[3], cur.ctrl_a[1:0]};
  assign ps_inc = cur.prescale_ticks + PS_W'(1);

  always_comb begin
    nxt    = cur;
    res    = '0;
    count1 = cur.count_value;
    ovf    = 1'b0;
    cma    = 1'b0;
    cmb    = 1'b0;
    case (op)
      OP_TICK: begin
        if (src != CS_STOP) begin
          case (src) inside
            CS_DIV1: count1 = cur.count_value + 8'd1;
            CS_DIV8, CS_DIV64, CS_DIV256, CS_DIV1024: begin
              if (ps_inc >= divider_of(src)) begin
                count1             = cur.count_value + 8'd1;
                nxt.prescale_ticks = '0;
              end else begin
                nxt.prescale_ticks = ps_inc;
              end
            end
            default: ;
          endcase
          ovf = (count1 == 8'd0);
          cma = (count1 == cur.compare_a);
          nxt.count_value = (cma && (mode == MODE_CLR_A || mode == MODE_CLR_B)) ?
                            8'd0 : count1;
          cmb = cur.irq_mask[FLAG_CMB] && (nxt.count_value == cur.compare_b);
          nxt.irq_flags = cur.irq_flags | {5'd0, cmb, cma, ovf};
          res.overflow_irq  = ovf & cur.irq_mask[FLAG_OVF];
          res.compare_a_irq = cma & cur.irq_mask[FLAG_CMA];
          res.compare_b_irq = cmb;
        end
      end
      OP_READ: begin
        unique case (reg_addr)
          REG_CTRL_A: res.read_data = cur.ctrl_a;
          REG_CTRL_B: res.read_data = cur.ctrl_b;
          REG_COUNT:  res.read_data = cur.count_value;
          REG_CMP_A:  res.read_data = cur.compare_a;
          REG_CMP_B:  res.read_data = cur.compare_b;
          REG_MASK:   res.read_data = cur.irq_mask;
          REG_FLAGS:  res.read_data = cur.irq_flags;
          default:    res.read_data = 8'd0;
        endcase
      end
      OP_WRITE: begin
        unique case (reg_addr)
          REG_CTRL_A: nxt.ctrl_a      = write_data;
          REG_CTRL_B: nxt.ctrl_b      = write_data;
          REG_COUNT:  nxt.count_value = write_data;
          REG_CMP_A:  nxt.compare_a   = write_data;
          REG_CMP_B:  nxt.compare_b   = write_data;
          REG_MASK:   nxt.irq_mask    = write_data;
          REG_FLAGS:  nxt.irq_flags   = write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
    res.flags_now = nxt.irq_flags[2:0];
  end

endmodule

>>> rtl/prescaled_timer_counter_8bit.sv
// ----------------------------------------------------------------------------
// prescaled_timer_counter_8bit
// 8-bit timer/counter with prescaler, overflow and two compare channels.
// ----------------------------------------------------------------------------
// One transaction per clock sustained while result_stall is low: each tick,
// read or write enters an input register, is then applied to the timer state
// and its result is loaded into the result register when that register
// advances. The rate is set by the state update (prescaler, count increment
// and compare), which every transaction passes once.
// result_stall holds the result register and, when the input register is
// also occupied, raises item_stall.
`include "assert_macros.svh"

module prescaled_timer_counter_8bit (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] operation,
  input  logic [2:0] reg_addr,
  input  logic [7:0] write_data,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] read_data,
  output logic [2:0] flags_now,
  output logic       overflow_irq,
  output logic       compare_a_irq,
  output logic       compare_b_irq
);
  import ptc8_pkg::*;

  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [2:0]  s1_addr;
  logic [7:0]  s1_data;
  tmr_state_t  tmr;
  tmr_state_t  tmr_next;
  tmr_result_t res_next;
  logic        advance;
  logic        take;

  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;
  assign take       = item_valid && !item_stall;

  ptc8_step u_step (
    .cur        (tmr),
    .op         (op_t'(s1_op)),
    .reg_addr   (s1_addr),
    .write_data (s1_data),
    .nxt        (tmr_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      tmr          <= '0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= s1_valid;
        if (s1_valid) begin
          tmr <= tmr_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_op   <= operation;
      s1_addr <= reg_addr;
      s1_data <= write_data;
    end
    if (advance && s1_valid) begin
      read_data     <= res_next.read_data;
      flags_now     <= res_next.flags_now;
      overflow_irq  <= res_next.overflow_irq;
      compare_a_irq <= res_next.compare_a_irq;
      compare_b_irq <= res_next.compare_b_irq;
    end
  end

  `ASSERT_CLK(a_stall_only_when_full, clk, rst, item_stall |-> (result_valid && result_stall && s1_valid), "item_stall without a full pipeline")
  `ASSERT_CLK(a_ovf_irq_sets_flag, clk, rst, (result_valid && overflow_irq) |-> flags_now[FLAG_OVF], "overflow pulse without overflow flag")
  `ASSERT_CLK(a_cmb_irq_sets_flag, clk, rst, (result_valid && compare_b_irq) |-> flags_now[FLAG_CMB], "compare B pulse without compare B flag")
  `ASSERT_CLK(a_irq_not_on_read, clk, rst, (result_valid && (overflow_irq || compare_a_irq || compare_b_irq)) |-> (read_data == 8'd0), "interrupt pulse on a read transaction")

endmodule

>>> tb/ptc8_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc8_checker
// Watches both channels of the 8-bit prescaled timer/counter. Every accepted
// input transaction is run through a local model of the timer registers and
// prescaler, and the predicted result is queued. Every accepted result is
// compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module ptc8_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_stall,
  input  logic [1:0] operation,
  input  logic [2:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic       result_valid,
  input  logic       result_stall,
  input  logic [7:0] read_data,
  input  logic [2:0] flags_now,
  input  logic       overflow_irq,
  input  logic       compare_a_irq,
  input  logic       compare_b_irq,
  output int         mismatch_cnt,
  output int         outstanding
);
  import ptc8_pkg::*;

  tmr_state_t  tmr;
  tmr_result_t step_results_q[$];

  task automatic timer_step(input logic [1:0] op, input logic [2:0] addr,
                            input logic [7:0] data, output tmr_result_t res);
    logic [2:0]      src;
    logic [2:0]      mode;
    logic [PS_W-1:0] limit;
    res = '0;
    case (op)
      OP_TICK: begin
        src = tmr.ctrl_b[2:0];
        if (src != CS_STOP) begin
          case (src)
            CS_DIV8:    limit = DIV_8;
            CS_DIV64:   limit = DIV_64;
            CS_DIV256:  limit = DIV_256;
            CS_DIV1024: limit = DIV_1024;
            default:    limit = '0;
          endcase
          if (src == CS_DIV1) begin
            tmr.count_value = tmr.count_value + 8'd1;
          end else if (limit != '0) begin
            tmr.prescale_ticks = tmr.prescale_ticks + PS_W'(1);
            if (tmr.prescale_ticks >= limit) begin
              tmr.count_value    = tmr.count_value + 8'd1;
              tmr.prescale_ticks = '0;
            end
          end
          if (tmr.count_value == 8'd0) begin
            tmr.irq_flags[FLAG_OVF] = 1'b1;
            res.overflow_irq        = tmr.irq_mask[FLAG_OVF];
          end
          if (tmr.count_value == tmr.compare_a) begin
            tmr.irq_flags[FLAG_CMA] = 1'b1;
            res.compare_a_irq       = tmr.irq_mask[FLAG_CMA];
            mode = {tmr.ctrl_b[3], tmr.ctrl_a[1:0]};
            if (mode == MODE_CLR_A || mode == MODE_CLR_B) tmr.count_value = 8'd0;
          end
          if (tmr.irq_mask[FLAG_CMB] && tmr.count_value == tmr.compare_b) begin
            tmr.irq_flags[FLAG_CMB] = 1'b1;
            res.compare_b_irq       = 1'b1;
          end
        end
      end
      OP_READ: begin
        case (addr)
          REG_CTRL_A: res.read_data = tmr.ctrl_a;
          REG_CTRL_B: res.read_data = tmr.ctrl_b;
          REG_COUNT:  res.read_data = tmr.count_value;
          REG_CMP_A:  res.read_data = tmr.compare_a;
          REG_CMP_B:  res.read_data = tmr.compare_b;
          REG_MASK:   res.read_data = tmr.irq_mask;
          REG_FLAGS:  res.read_data = tmr.irq_flags;
          default:    res.read_data = 8'd0;
        endcase
      end
      OP_WRITE: begin
        case (addr)
          REG_CTRL_A: tmr.ctrl_a      = data;
          REG_CTRL_B: tmr.ctrl_b      = data;
          REG_COUNT:  tmr.count_value = data;
          REG_CMP_A:  tmr.compare_a   = data;
          REG_CMP_B:  tmr.compare_b   = data;
          REG_MASK:   tmr.irq_mask    = data;
          REG_FLAGS:  tmr.irq_flags   = data;
          default:    ;
        endcase
      end
      default: ;
    endcase
    res.flags_now = tmr.irq_flags[2:0];
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch %s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : monitor
    tmr_result_t exp_r;
    tmr_result_t new_r;
    if (rst) begin
      tmr = '0;
      step_results_q.delete();
      mismatch_cnt = 0;
      outstanding <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (step_results_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result transaction: read_data %0h flags %0h",
                     read_data, flags_now);
        end else begin
          exp_r = step_results_q.pop_front();
          check_field("read_data", exp_r.read_data, read_data);
          check_field("flags_now", exp_r.flags_now, flags_now);
          check_field("overflow_irq", exp_r.overflow_irq, overflow_irq);
          check_field("compare_a_irq", exp_r.compare_a_irq, compare_a_irq);
          check_field("compare_b_irq", exp_r.compare_b_irq, compare_b_irq);
        end
      end
      if (item_valid && !item_stall) begin
        timer_step(operation, reg_addr, write_data, new_r);
        step_results_q.push_back(new_r);
      end
      outstanding <= step_results_q.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 8-bit prescaled timer/counter. A directed
// sequence covers stopped clock, unused address and operation, overflow,
// both compare channels, count clear in both clearing wave modes and the
// masked compare B. Random phases then set up the registers near a match
// and run ticks under every clock source, mixed with reads and stray
// writes, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import ptc8_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [2:0] REG_UNUSED   = 3'd7;
  localparam logic [2:0] CS_EXT_A     = 3'd6;
  localparam logic [2:0] CS_EXT_B     = 3'd7;
  localparam logic [7:0] CTRL_B_WAVE2 = 8'h08;
  localparam int         ITEM_TARGET  = 550;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [1:0] operation = OP_TICK;
  logic [2:0] reg_addr = 3'd0;
  logic [7:0] write_data = 8'd0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] read_data;
  logic [2:0] flags_now;
  logic       overflow_irq;
  logic       compare_a_irq;
  logic       compare_b_irq;

  int mismatch_cnt;
  int outstanding;
  int n_items = 0;
  int idle_cycles = 0;
  bit idle_on = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  prescaled_timer_counter_8bit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .operation(operation), .reg_addr(reg_addr), .write_data(write_data),
    .result_valid(result_valid), .result_stall(result_stall),
    .read_data(read_data), .flags_now(flags_now),
    .overflow_irq(overflow_irq), .compare_a_irq(compare_a_irq),
    .compare_b_irq(compare_b_irq)
  );

  ptc8_checker chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .operation(operation), .reg_addr(reg_addr), .write_data(write_data),
    .result_valid(result_valid), .result_stall(result_stall),
    .read_data(read_data), .flags_now(flags_now),
    .overflow_irq(overflow_irq), .compare_a_irq(compare_a_irq),
    .compare_b_irq(compare_b_irq),
    .mismatch_cnt(mismatch_cnt), .outstanding(outstanding)
  );

  task automatic send_item(input logic [1:0] op, input logic [2:0] addr,
                           input logic [7:0] data);
    int gap;
    item_valid <= 1'b1;
    operation  <= op;
    reg_addr   <= addr;
    write_data <= data;
    do @(posedge clk); while (item_stall);
    n_items++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && idle_on && $urandom_range(0, 9) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [7:0] cmp_a;
    logic [7:0] cmp_b;
    logic [7:0] cnt;
    logic [2:0] src;
    int         r;
    int         n_ticks;
    int         phase;
    phase = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item(OP_READ, REG_FLAGS, 8'h00);
    send_item(OP_TICK, REG_CTRL_A, 8'h00);          // stopped clock
    send_item(OP_WRITE, REG_UNUSED, 8'hFF);
    send_item(OP_READ, REG_UNUSED, 8'h00);
    send_item(OP_UNUSED, REG_COUNT, 8'hFF);
    send_item(OP_WRITE, REG_MASK, 8'hFF);
    send_item(OP_WRITE, REG_CMP_A, 8'hFF);
    send_item(OP_WRITE, REG_CMP_B, 8'h00);
    send_item(OP_WRITE, REG_COUNT, 8'hFE);
    send_item(OP_WRITE, REG_CTRL_B, {5'd0, CS_DIV1});
    send_item(OP_TICK, REG_CTRL_A, 8'h00);          // compare A
    send_item(OP_TICK, REG_CTRL_A, 8'h00);          // wrap, overflow and compare B
    send_item(OP_WRITE, REG_CTRL_A, 8'h02);
    send_item(OP_WRITE, REG_COUNT, 8'hFE);
    send_item(OP_TICK, REG_CTRL_A, 8'h00);          // clear on compare A
    send_item(OP_WRITE, REG_CTRL_A, 8'h03);
    send_item(OP_WRITE, REG_CTRL_B, CTRL_B_WAVE2 | {5'd0, CS_DIV1});
    send_item(OP_WRITE, REG_COUNT, 8'hFE);
    send_item(OP_TICK, REG_CTRL_A, 8'h00);
    send_item(OP_WRITE, REG_MASK, 8'hFB);           // compare B masked
    send_item(OP_WRITE, REG_CMP_B, 8'h01);
    send_item(OP_TICK, REG_CTRL_A, 8'h00);
    send_item(OP_WRITE, REG_FLAGS, 8'hF8);
    send_item(OP_READ, REG_FLAGS, 8'h00);
    send_item(OP_READ, REG_MASK, 8'h00);

    while (n_items < ITEM_TARGET) begin
      phase++;
      if (n_items >= ITEM_TARGET - 100) idle_on <= 1'b0;
      else idle_on <= ($urandom_range(0, 3) != 0);

      r = $urandom_range(0, 9);
      case (r)
        0, 1, 2, 3: src = CS_DIV1;
        4:          src = CS_DIV8;
        5:          src = CS_DIV64;
        6:          src = CS_DIV256;
        7:          src = CS_DIV1024;
        8:          src = ($urandom_range(0, 1) != 0) ? CS_EXT_A : CS_EXT_B;
        default:    src = CS_STOP;
      endcase
      cmp_a = 8'($urandom);
      cmp_b = ($urandom_range(0, 1) != 0) ? cmp_a + 8'($urandom_range(0, 3))
                                          : 8'($urandom);
      case ($urandom_range(0, 2))
        0:       cnt = cmp_a - 8'($urandom_range(0, 6));
        1:       cnt = cmp_b - 8'($urandom_range(0, 6));
        default: cnt = 8'hFF - 8'($urandom_range(0, 6));
      endcase

      if ($urandom_range(0, 3) != 0) send_item(OP_WRITE, REG_CTRL_A, 8'($urandom));
      if ($urandom_range(0, 3) != 0) send_item(OP_WRITE, REG_CMP_A, cmp_a);
      if ($urandom_range(0, 3) != 0) send_item(OP_WRITE, REG_CMP_B, cmp_b);
      if ($urandom_range(0, 3) != 0) send_item(OP_WRITE, REG_COUNT, cnt);
      if ($urandom_range(0, 2) != 0) send_item(OP_WRITE, REG_MASK, 8'($urandom));
      if ($urandom_range(0, 3) == 0) send_item(OP_WRITE, REG_FLAGS, 8'($urandom));
      send_item(OP_WRITE, REG_CTRL_B, {5'($urandom), src});

      n_ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 80)
                                            : $urandom_range(3, 24);
      for (int k = 0; k < n_ticks; k++) begin
        r = $urandom_range(0, 15);
        if (r < 12) send_item(OP_TICK, 3'($urandom), 8'($urandom));
        else if (r == 12) send_item(OP_READ, 3'($urandom), 8'($urandom));
        else if (r == 13) send_item(OP_WRITE, 3'($urandom), 8'($urandom));
        else if (r == 14) send_item(OP_UNUSED, 3'($urandom), 8'($urandom));
        else send_item(OP_READ, REG_COUNT, 8'($urandom));
      end

      if (phase == 5 || $urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
